@@ src/krc_pkg.sv @@
package krc_pkg;

	localparam int KEY_WIDTH  = 32;
	localparam int DATA_WIDTH = 32;
	localparam int CFG_WIDTH  = 5;

	// Request kinds carried in the kind field.
	localparam logic KIND_PUSH   = 1'b0;
	localparam logic KIND_LOOKUP = 1'b1;

	typedef struct packed {
		logic                  kind;
		logic [KEY_WIDTH-1:0]  key;
		logic [DATA_WIDTH-1:0] data;
	} req_t;

	typedef struct packed {
		logic                  hit;
		logic [DATA_WIDTH-1:0] data_res;
	} rsp_t;

	// Search token handed from one cell to the next. The recent flag marks a
	// hit taken from the part of the ring written since the pointer last wrapped.
	typedef struct packed {
		logic                  act;
		logic                  hit;
		logic                  recent;
		logic [DATA_WIDTH-1:0] data;
	} chain_t;

endpackage

@@ src/keyed_ring_cache_core.sv @@
// Keyed ring cache: a small associative store with first-in first-out
// replacement, built as a row of DEPTH cells, one entry per cell.
// Requests arrive on req (valid/ready). A push writes key and data into the
// entry at the replacement pointer, which then advances and wraps at the
// number of entries in use; a push leaves the block ready and gives no response.
// A lookup sends a search token through the row of cells, one cell per
// cycle; the block takes no further request from acceptance until the
// result has moved into the output register. The response holds hit and
// the data of the newest matching entry, or zero data on a miss.
// The cfg channel writes the number of entries in use; cfg_ready is always
// high, and writes are expected only while no request is in flight.
// Reset clears all valid bits, the pointer and the response register, and
// sets the size in use to 16 (or DEPTH if smaller).
// When the receiver stalls, the response waits in the output register; a
// further lookup may still run and parks its result until the register frees.
module keyed_ring_cache_core #(
	parameter int DEPTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  krc_pkg::req_t                  req,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output krc_pkg::rsp_t                  rsp,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [krc_pkg::CFG_WIDTH-1:0]  cfg_data
);
	import krc_pkg::*;

	localparam int IDX_W    = $clog2(DEPTH);
	localparam int CNT_W    = $clog2(DEPTH + 1);
	localparam int SIZE_RST = (DEPTH < 16) ? DEPTH : 16;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_HOLD
	} state_t;

	state_t                state_q;
	logic [IDX_W-1:0]      ptr_q;
	logic [CNT_W-1:0]      size_q;
	logic [KEY_WIDTH-1:0]  key_q;
	logic                  start_q;
	logic                  rsp_valid_q;
	rsp_t                  rsp_q;
	rsp_t                  pend_q;

	logic [CNT_W-1:0]      cfg_size;
	logic [CNT_W-1:0]      ptr_eff;
	logic [CNT_W-1:0]      ptr_inc;
	logic [CNT_W-1:0]      ptr_next;
	logic                  req_acc;
	logic                  push_acc;
	logic                  rsp_free;
	logic                  rsp_load;
	logic [DEPTH-1:0]      wr_sel;
	chain_t                chain [DEPTH+1];
	chain_t                tail;

	// Size in use: zero acts as one, anything above DEPTH saturates.
	always_comb begin
		if (cfg_data == '0) begin
			cfg_size = CNT_W'(1);
		end else if (32'(cfg_data) > 32'(DEPTH)) begin
			cfg_size = CNT_W'(DEPTH);
		end else begin
			cfg_size = CNT_W'(cfg_data);
		end
	end

	// A pointer left beyond a lowered size restarts at entry zero.
	assign ptr_eff  = (CNT_W'(ptr_q) >= size_q) ? '0 : CNT_W'(ptr_q);
	assign ptr_inc  = ptr_eff + CNT_W'(1);
	assign ptr_next = (ptr_inc >= size_q) ? '0 : ptr_inc;

	assign req_ready = (state_q == ST_IDLE);
	assign req_acc   = req_valid && req_ready;
	assign push_acc  = req_acc && (req.kind == KIND_PUSH);
	assign rsp_free  = !rsp_valid_q || rsp_ready;
	assign cfg_ready = 1'b1;

	// A final search result moves into the output register in this cycle,
	// either straight from the tail of the row or from the parking register.
	assign rsp_load = rsp_free &&
		(((state_q == ST_SEARCH) && tail.act) || (state_q == ST_HOLD));

	// The token enters the first cell empty; each cell may replace the
	// candidate with its own entry as the token passes.
	assign chain[0] = '{act: start_q, hit: 1'b0, recent: 1'b0, data: '0};
	assign tail     = chain[DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign wr_sel[i] = push_acc && (ptr_eff == CNT_W'(i));

		krc_cell #(
			.DEPTH (DEPTH),
			.INDEX (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.wr_en     (wr_sel[i]),
			.wr_key    (req.key),
			.wr_data   (req.data),
			.look_key  (key_q),
			.size      (size_q),
			.ptr       (ptr_eff),
			.chain_in  (chain[i]),
			.chain_out (chain[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ptr_q       <= '0;
			size_q      <= CNT_W'(SIZE_RST);
			key_q       <= '0;
			start_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
			pend_q      <= '0;
		end else begin
			start_q <= req_acc && (req.kind == KIND_LOOKUP);
			if (cfg_valid) begin
				size_q <= cfg_size;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (push_acc) begin
						ptr_q <= IDX_W'(ptr_next);
					end else if (req_acc) begin
						key_q   <= req.key;
						state_q <= ST_SEARCH;
					end
				end
				ST_SEARCH: begin
					if (tail.act) begin
						// The token has left the last cell: the candidate is final.
						if (rsp_free) begin
							rsp_q   <= '{hit: tail.hit, data_res: tail.data};
							state_q <= ST_IDLE;
						end else begin
							pend_q  <= '{hit: tail.hit, data_res: tail.data};
							state_q <= ST_HOLD;
						end
					end
				end
				ST_HOLD: begin
					if (rsp_free) begin
						rsp_q   <= pend_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

@@ src/krc_cell.sv @@
module krc_cell #(
	parameter int DEPTH = 16,
	parameter int INDEX = 0
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                wr_en,
	input  logic [krc_pkg::KEY_WIDTH-1:0]       wr_key,
	input  logic [krc_pkg::DATA_WIDTH-1:0]      wr_data,
	input  logic [krc_pkg::KEY_WIDTH-1:0]       look_key,
	input  logic [$clog2(DEPTH+1)-1:0]          size,
	input  logic [$clog2(DEPTH+1)-1:0]          ptr,
	input  krc_pkg::chain_t                     chain_in,
	output krc_pkg::chain_t                     chain_out
);
	import krc_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);

	logic                  valid_q;
	logic [KEY_WIDTH-1:0]  key_q;
	logic [DATA_WIDTH-1:0] data_q;
	chain_t                chain_q;
	logic                  in_range;
	logic                  recent;
	logic                  match;
	logic                  take;

	// Entries below the pointer were written after those at or above it, so
	// they win; within one group the higher index is newer and comes later.
	assign in_range = CNT_W'(INDEX) < size;
	assign recent   = CNT_W'(INDEX) < ptr;
	assign match    = valid_q && in_range && (key_q == look_key);
	assign take     = chain_in.act && match && (recent || !chain_in.recent);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			chain_q <= '0;
		end else begin
			if (wr_en) begin
				valid_q <= 1'b1;
			end
			chain_q.act <= chain_in.act;
			if (take) begin
				chain_q.hit    <= 1'b1;
				chain_q.recent <= recent;
				chain_q.data   <= data_q;
			end else begin
				chain_q.hit    <= chain_in.hit;
				chain_q.recent <= chain_in.recent;
				chain_q.data   <= chain_in.data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_q  <= wr_key;
			data_q <= wr_data;
		end
	end

	assign chain_out = chain_q;

endmodule
